### hw/rtl/ctd_pkg.sv
// Package: shared types and constants of the cooperative task dispatcher.
`timescale 1ns / 1ps
package ctd_pkg;

   localparam int unsigned MaxTasksDefault = 16;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_BEGIN = 3'd1,
      OP_VISIT = 3'd2,
      OP_REPORT = 3'd3,
      OP_END   = 3'd4
   } op_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_SETUP  = 3'd1;
   localparam logic [2:0] ACT_LOOP   = 3'd2;
   localparam logic [2:0] ACT_SKIP   = 3'd3;
   localparam logic [2:0] ACT_FINISH = 3'd4;

   localparam logic [1:0] LIFE_NEW    = 2'd0;
   localparam logic [1:0] LIFE_RUN    = 2'd1;
   localparam logic [1:0] LIFE_KILLED = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  priority_req;
      logic        is_interval;
      logic [31:0] interval_time;
      logic [31:0] time_now;
      logic        ran_ok;
      logic [31:0] run_duration;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  action;
      logic [4:0]  task_id;
      logic [31:0] executions;
      logic [31:0] interval_busy_time;
      logic [31:0] idle_busy_time;
      logic [31:0] scheduler_time;
   } rsp_type;

   // Per-task record kept in the task memory.
   typedef struct packed {
      logic [7:0]  prio;
      logic        kind;
      logic [31:0] period;
      logic [1:0]  life;
      logic [31:0] deadline;
      logic [31:0] last_run;
      logic [31:0] worst;
      logic [31:0] count;
   } task_rec_type;

endpackage

### hw/rtl/cooperative_task_dispatcher_core.sv
// Sequence: begin, end, rejected ops and a visit past the last task answer straight from idle;
// visit and report read the order entry, then the task record, and report writes it back; add
// writes the record, then walks down the order table moving entries up one slot to find its slot.
// Flow: one item at a time; the next item is taken only after the result has been transferred.
// Reset clears counters, scan phase and sums; the task memories hold no reset and are
// read only at entries an add has written.
`timescale 1ns / 1ps
module cooperative_task_dispatcher_core #(
   parameter int unsigned MaxTasks = ctd_pkg::MaxTasksDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ctd_pkg::rsp_type rsp_data
);
   import ctd_pkg::*;

   localparam int unsigned IdxW = $clog2(MaxTasks);
   localparam int unsigned CntW = $clog2(MaxTasks + 1);
   localparam int unsigned RecW = $bits(task_rec_type);

   typedef enum logic [2:0] {
      S_IDLE, S_ORD_RD, S_EXEC, S_SHIFT_RD, S_SHIFT_ORD, S_SHIFT_CHK, S_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_OPEN, PH_WAIT_SETUP, PH_WAIT_LOOP
   } phase_type;

   state_type      state_ff, state_in;
   phase_type      phase_ff, phase_in;
   req_type        req_ff, req_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] cursor_ff, cursor_in;
   logic [CntW-1:0] ins_ff, ins_in;     // insertion slot during add
   logic [IdxW-1:0] tid_ff, tid_in;     // task under work
   logic [IdxW-1:0] mov_ff, mov_in;     // order entry being moved
   logic [31:0]    start_ff, start_in, nearest_ff, nearest_in, scan_busy_ff, scan_busy_in;
   logic [31:0]    ibusy_ff, ibusy_in, dbusy_ff, dbusy_in, over_ff, over_in;
   logic [31:0]    visit_ff, visit_in;

   // Memory ports
   logic            ord_we, task_we;
   logic [IdxW-1:0] ord_wa, ord_ra, ord_rd, task_wa, task_ra;
   logic [IdxW-1:0] ord_wd;
   task_rec_type    task_wd, task_rd;
   logic [RecW-1:0] task_rd_raw;

   ctd_ram #(.Width(IdxW), .Depth(MaxTasks)) u_order (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_addr(ord_ra), .rd_data(ord_rd));

   ctd_ram #(.Width(RecW), .Depth(MaxTasks)) u_tasks (
      .clock(clock), .wr_en(task_we), .wr_addr(task_wa), .wr_data(task_wd),
      .rd_addr(task_ra), .rd_data(task_rd_raw));

   assign task_rd = task_rec_type'(task_rd_raw);

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic rsp_type mk(input logic [1:0] st, input logic [2:0] act,
                                  input logic [4:0] id, input logic [31:0] ex,
                                  input logic [31:0] ib, input logic [31:0] db,
                                  input logic [31:0] ov);
      rsp_type r;
      r.status = st; r.action = act; r.task_id = id; r.executions = ex;
      r.interval_busy_time = ib; r.idle_busy_time = db; r.scheduler_time = ov;
      return r;
   endfunction

   logic [4:0]   tid_ext;
   logic         go;
   logic         ahead;
   task_rec_type upd;
   logic [31:0]  near_v;
   logic [31:0]  fit_sum;

   assign tid_ext = 5'(tid_ff) + 5'd1;
   assign fit_sum = task_rd.worst + req_ff.time_now;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; req_in = req_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff; count_in = count_ff; cursor_in = cursor_ff;
      ins_in = ins_ff; tid_in = tid_ff; mov_in = mov_ff; start_in = start_ff;
      nearest_in = nearest_ff; scan_busy_in = scan_busy_ff; ibusy_in = ibusy_ff;
      dbusy_in = dbusy_ff; over_in = over_ff; visit_in = visit_ff;
      ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
      ord_ra = cursor_ff[IdxW-1:0];
      task_we = 1'b0; task_wa = tid_ff; task_wd = task_rd; task_ra = tid_ff;
      go = 1'b0; ahead = 1'b0; upd = task_rd; near_v = nearest_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               state_in = S_RESP;
               rsp_in = mk(ST_BAD, ACT_NONE, 5'd0, 32'd0, ibusy_ff, dbusy_ff, over_ff);
               unique case (req_data.operation)
                  OP_ADD: begin
                     if (phase_ff != PH_IDLE) begin
                     end else if (count_ff >= CntW'(MaxTasks)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        tid_in = count_ff[IdxW-1:0];
                        ins_in = count_ff;
                        task_we = 1'b1;
                        task_wa = count_ff[IdxW-1:0];
                        task_wd = '{prio: req_data.priority_req, kind: req_data.is_interval,
                                    period: req_data.interval_time, life: LIFE_NEW,
                                    deadline: 32'd0, last_run: 32'd0, worst: 32'd0,
                                    count: 32'd0};
                        state_in = S_SHIFT_RD;
                     end
                  end
                  OP_BEGIN: begin
                     if (phase_ff == PH_IDLE) begin
                        start_in = req_data.time_now; cursor_in = '0;
                        nearest_in = '1; scan_busy_in = '0; phase_in = PH_OPEN;
                        rsp_in.status = ST_OK;
                     end
                  end
                  OP_VISIT: begin
                     if (phase_ff == PH_OPEN) begin
                        if (cursor_ff >= count_ff) begin
                           rsp_in.status = ST_OK; rsp_in.action = ACT_FINISH;
                        end else begin
                           state_in = S_ORD_RD;
                        end
                     end
                  end
                  OP_REPORT: begin
                     if (phase_ff == PH_WAIT_SETUP || phase_ff == PH_WAIT_LOOP)
                        state_in = S_ORD_RD;
                  end
                  OP_END: begin
                     if (phase_ff == PH_OPEN) begin
                        over_in = over_ff + (req_data.time_now - start_ff - scan_busy_ff);
                        phase_in = PH_IDLE;
                        rsp_in = mk(ST_OK, ACT_FINISH, 5'd0, 32'd0, ibusy_ff, dbusy_ff,
                                    over_in);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ORD_RD: begin
            // order memory output is valid now; fetch the task record
            tid_in = ord_rd;
            task_ra = ord_rd;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (req_ff.operation == OP_VISIT) begin
               visit_in = req_ff.time_now;
               if (task_rd.life == LIFE_NEW) begin
                  phase_in = PH_WAIT_SETUP;
                  rsp_in = mk(ST_OK, ACT_SETUP, tid_ext, 32'd0, ibusy_ff, dbusy_ff, over_ff);
               end else begin
                  if (task_rd.life == LIFE_RUN) begin
                     if (task_rd.kind) begin
                        if (task_rd.deadline < nearest_ff) near_v = task_rd.deadline;
                        go = start_ff >= task_rd.deadline;
                     end else begin
                        go = fit_sum < nearest_ff;
                     end
                  end
                  nearest_in = near_v;
                  if (go) begin
                     phase_in = PH_WAIT_LOOP;
                     rsp_in = mk(ST_OK, ACT_LOOP, tid_ext, 32'd0, ibusy_ff, dbusy_ff,
                                 over_ff);
                  end else begin
                     cursor_in = cursor_ff + CntW'(1);
                     rsp_in = mk(ST_OK, ACT_SKIP, tid_ext, 32'd0, ibusy_ff, dbusy_ff,
                                 over_ff);
                  end
               end
            end else begin
               if (phase_ff == PH_WAIT_SETUP) begin
                  upd.life = req_ff.ran_ok ? LIFE_RUN : LIFE_KILLED;
                  upd.deadline = start_ff;
                  upd.last_run = start_ff;
               end else begin
                  if (!req_ff.ran_ok) upd.life = LIFE_KILLED;
                  upd.deadline = task_rd.deadline + task_rd.period;
                  upd.last_run = visit_ff + req_ff.run_duration;
                  if (req_ff.run_duration > task_rd.worst) upd.worst = req_ff.run_duration;
                  if (task_rd.kind) ibusy_in = ibusy_ff + req_ff.run_duration;
                  else dbusy_in = dbusy_ff + req_ff.run_duration;
                  scan_busy_in = scan_busy_ff + req_ff.run_duration;
               end
               upd.count = task_rd.count + 32'd1;
               task_we = 1'b1; task_wa = tid_ff; task_wd = upd;
               cursor_in = cursor_ff + CntW'(1);
               phase_in = PH_OPEN;
               rsp_in = mk(ST_OK, ACT_NONE, tid_ext, upd.count, ibusy_in, dbusy_in, over_ff);
            end
         end
         S_SHIFT_RD: begin
            // read order entry just below the insertion slot
            if (ins_ff == '0) begin
               ord_we = 1'b1; ord_wa = '0; ord_wd = tid_ff;
               count_in = count_ff + CntW'(1);
               rsp_in = mk(ST_OK, ACT_NONE, tid_ext, 32'd0, ibusy_ff, dbusy_ff, over_ff);
               state_in = S_RESP;
            end else begin
               ord_ra = IdxW'(ins_ff - CntW'(1));
               state_in = S_SHIFT_ORD;
            end
         end
         S_SHIFT_ORD: begin
            // order data back; fetch the record of the task it names
            mov_in = ord_rd;
            task_ra = ord_rd;
            state_in = S_SHIFT_CHK;
         end
         S_SHIFT_CHK: begin
            ahead = (req_ff.is_interval == task_rd.kind &&
                     req_ff.priority_req < task_rd.prio) ||
                    (req_ff.is_interval && !task_rd.kind);
            ord_we = 1'b1;
            ord_wa = ins_ff[IdxW-1:0];
            if (ahead) begin
               // move the entry up one slot and keep walking down
               ord_wd = mov_ff;
               ins_in = ins_ff - CntW'(1);
               state_in = S_SHIFT_RD;
            end else begin
               ord_wd = tid_ff;
               count_in = count_ff + CntW'(1);
               rsp_in = mk(ST_OK, ACT_NONE, tid_ext, 32'd0, ibusy_ff, dbusy_ff, over_ff);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; phase_ff <= PH_IDLE; rsp_valid_ff <= 1'b0;
         count_ff <= '0; cursor_ff <= '0; start_ff <= '0; nearest_ff <= '1;
         scan_busy_ff <= '0; ibusy_ff <= '0; dbusy_ff <= '0; over_ff <= '0;
         visit_ff <= '0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in; cursor_ff <= cursor_in; start_ff <= start_in;
         nearest_ff <= nearest_in; scan_busy_ff <= scan_busy_in; ibusy_ff <= ibusy_in;
         dbusy_ff <= dbusy_in; over_ff <= over_in; visit_ff <= visit_in;
      end
      req_ff <= req_in; rsp_ff <= rsp_in; ins_ff <= ins_in; tid_ff <= tid_in;
      mov_ff <= mov_in;
   end

`ifndef SYNTHESIS
   // hold a waiting result steady until it is transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data));
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid));
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxTasks));
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= count_ff);
`endif
endmodule

### hw/rtl/ctd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ctd_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
